// ----- hdl/wtt_pkg.sv -----
// ----------------------------------------------------------------------------
// wtt_pkg: shared types, constants and coefficient tables
// Winograd tile transform: mode codes, size tables, controller status/commands.
// ----------------------------------------------------------------------------
package wtt_pkg;

  localparam int unsigned OutputTile = 4;
  localparam int unsigned KernelSize = 3;
  localparam int unsigned TileSpan   = OutputTile + KernelSize - 1;
  localparam int unsigned StoreDepth = TileSpan * TileSpan;
  localparam int unsigned FracBits   = 14;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned IdxW       = $clog2(TileSpan);
  localparam int unsigned AccW       = 72;

  typedef enum logic [2:0] {
    MODE_WEIGHT   = 3'd0,
    MODE_INPUT    = 3'd1,
    MODE_OUTPUT   = 3'd2,
    MODE_GRADIENT = 3'd3,
    MODE_UPDATE   = 3'd4
  } mode_e;

  typedef enum logic {
    REG_MODE   = 1'b0,
    REG_INVERT = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS1,
    ST_PASS2,
    ST_DRAIN
  } state_e;

  // Controller to datapath: one MAC step
  typedef struct packed {
    logic             stage2;   // 0: P = A*X, 1: Y = P*A^T
    logic [IdxW-1:0]  i;
    logic [IdxW-1:0]  j;
    logic [IdxW-1:0]  k;
    logic             first;    // clear accumulator
    logic             fire;     // issue a product
    logic             last_k;   // product closes the sum
    logic             last_el;  // element is last of tile
  } mac_cmd_t;

  function automatic logic valid_mode(logic [2:0] m);
    return m <= 3'(MODE_UPDATE);
  endfunction

  function automatic logic [IdxW-1:0] size_in(logic [2:0] m);
    case (m)
      3'(MODE_WEIGHT):   return IdxW'(KernelSize);
      3'(MODE_GRADIENT): return IdxW'(OutputTile);
      default:           return IdxW'(TileSpan);
    endcase
  endfunction

  function automatic logic [IdxW-1:0] size_out(logic [2:0] m);
    case (m)
      3'(MODE_OUTPUT): return IdxW'(OutputTile);
      3'(MODE_UPDATE): return IdxW'(KernelSize);
      default:         return IdxW'(TileSpan);
    endcase
  endfunction

  // Q3.14 coefficient table, 18-bit signed (8/3 needs 16 magnitude bits)
  function automatic logic signed [17:0] coef(logic [2:0] m, logic [IdxW-1:0] r,
                                              logic [IdxW-1:0] c);
    logic [5:0] rc;
    rc = {r, c};
    case (m)
      3'(MODE_WEIGHT): begin
        case (rc)
          {3'd0, 3'd0}: return 18'sd16384;
          {3'd1, 3'd0}, {3'd1, 3'd1}, {3'd1, 3'd2}: return 18'sd10923;
          {3'd2, 3'd0}, {3'd2, 3'd2}: return 18'sd10923;
          {3'd2, 3'd1}: return -18'sd10923;
          {3'd3, 3'd0}, {3'd4, 3'd0}: return 18'sd5461;
          {3'd3, 3'd1}: return 18'sd10923;
          {3'd4, 3'd1}: return -18'sd10923;
          {3'd3, 3'd2}, {3'd4, 3'd2}: return 18'sd21845;
          {3'd5, 3'd2}: return 18'sd32768;
          default: return '0;
        endcase
      end
      3'(MODE_INPUT): begin
        case (rc)
          {3'd0, 3'd0}: return 18'sd16384;
          {3'd0, 3'd2}: return -18'sd20480;
          {3'd0, 3'd4}: return 18'sd4096;
          {3'd1, 3'd1}, {3'd1, 3'd2}: return 18'sd16384;
          {3'd1, 3'd3}, {3'd1, 3'd4}: return -18'sd4096;
          {3'd2, 3'd1}: return -18'sd16384;
          {3'd2, 3'd2}: return 18'sd16384;
          {3'd2, 3'd3}: return 18'sd4096;
          {3'd2, 3'd4}: return -18'sd4096;
          {3'd3, 3'd1}: return -18'sd16384;
          {3'd3, 3'd2}: return -18'sd8192;
          {3'd3, 3'd3}: return 18'sd16384;
          {3'd3, 3'd4}: return 18'sd8192;
          {3'd4, 3'd1}: return 18'sd16384;
          {3'd4, 3'd2}: return -18'sd8192;
          {3'd4, 3'd3}: return -18'sd16384;
          {3'd4, 3'd4}: return 18'sd8192;
          {3'd5, 3'd1}: return 18'sd16384;
          {3'd5, 3'd3}: return -18'sd20480;
          {3'd5, 3'd5}: return 18'sd4096;
          default: return '0;
        endcase
      end
      3'(MODE_OUTPUT), 3'(MODE_UPDATE): begin
        case (rc)
          {3'd0, 3'd0}, {3'd0, 3'd1}, {3'd0, 3'd2}: return 18'sd16384;
          {3'd0, 3'd3}, {3'd0, 3'd4}: return 18'sd4096;
          {3'd1, 3'd1}: return 18'sd16384;
          {3'd1, 3'd2}: return -18'sd16384;
          {3'd1, 3'd3}: return 18'sd8192;
          {3'd1, 3'd4}: return -18'sd8192;
          {3'd2, 3'd1}, {3'd2, 3'd2}, {3'd2, 3'd3}, {3'd2, 3'd4}: return 18'sd16384;
          {3'd2, 3'd5}: return (m == 3'(MODE_UPDATE)) ? 18'sd32768 : 18'sd0;
          {3'd3, 3'd1}: return (m == 3'(MODE_OUTPUT)) ? 18'sd16384 : 18'sd0;
          {3'd3, 3'd2}: return (m == 3'(MODE_OUTPUT)) ? -18'sd16384 : 18'sd0;
          {3'd3, 3'd3}, {3'd3, 3'd5}:
            return (m == 3'(MODE_OUTPUT)) ? 18'sd32768 : 18'sd0;
          {3'd3, 3'd4}: return (m == 3'(MODE_OUTPUT)) ? -18'sd32768 : 18'sd0;
          default: return '0;
        endcase
      end
      3'(MODE_GRADIENT): begin
        case (rc)
          {3'd0, 3'd0}: return 18'sd16384;
          {3'd1, 3'd0}, {3'd1, 3'd1}, {3'd1, 3'd2}, {3'd1, 3'd3}: return 18'sd10923;
          {3'd2, 3'd0}, {3'd2, 3'd2}: return 18'sd10923;
          {3'd2, 3'd1}, {3'd2, 3'd3}: return -18'sd10923;
          {3'd3, 3'd0}, {3'd4, 3'd0}: return 18'sd5461;
          {3'd3, 3'd1}: return 18'sd10923;
          {3'd4, 3'd1}: return -18'sd10923;
          {3'd3, 3'd2}, {3'd4, 3'd2}: return 18'sd21845;
          {3'd3, 3'd3}: return 18'sd43691;
          {3'd4, 3'd3}: return -18'sd43691;
          {3'd5, 3'd3}: return 18'sd32768;
          default: return '0;
        endcase
      end
      default: return '0;
    endcase
  endfunction

endpackage

// ----- hdl/wtt_ctrl.sv -----
// ----------------------------------------------------------------------------
// wtt_ctrl: sequencer for load, two MAC passes and result drain
// Walks (i, j, k) one product per cycle except busy stalls in pass 2; handles handshakes.
// ----------------------------------------------------------------------------
module wtt_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [2:0]              mode_i,
  input  logic                    cfg_restart_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    load_we_o,
  output logic [wtt_pkg::AddrW-1:0] load_addr_o,
  output wtt_pkg::mac_cmd_t       cmd_o,
  input  logic                    drain_busy_i
);
  import wtt_pkg::*;

  state_e           state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [IdxW-1:0]  n, r;
  logic [AddrW-1:0] total;
  logic             jmax;

  assign n     = size_in(mode_i);
  assign r     = size_out(mode_i);
  assign total = AddrW'(n) * AddrW'(n);
  assign jmax  = (j_q == ((state_q == ST_PASS1) ? n : r) - 1'b1);

  // State and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    in_ready_o  = 1'b0;
    load_we_o   = 1'b0;
    load_addr_o = cnt_q;
    cmd_o       = '0;
    cmd_o.i     = i_q;
    cmd_o.j     = j_q;
    cmd_o.k     = k_q;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (cfg_restart_i) begin
          cnt_d = '0;
        end else if (in_valid_i) begin
          if (!valid_mode(mode_i)) begin
            cnt_d = '0;
          end else begin
            load_we_o = 1'b1;
            if (cnt_q == total - 1'b1) begin
              cnt_d   = '0;
              state_d = ST_PASS1;
              i_d     = '0;
              j_d     = '0;
              k_d     = '0;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
      end
      ST_PASS1, ST_PASS2: begin
        cmd_o.stage2  = (state_q == ST_PASS2);
        cmd_o.fire    = 1'b1;
        cmd_o.first   = (k_q == '0);
        cmd_o.last_k  = (k_q == n - 1'b1);
        cmd_o.last_el = (i_q == r - 1'b1) && jmax;
        if (state_q == ST_PASS2 && k_q == '0 && drain_busy_i) begin
          cmd_o.fire = 1'b0;    // hold while the MAC pipe or output is busy
        end else if (k_q != n - 1'b1) begin
          k_d = k_q + 1'b1;
        end else begin
          k_d = '0;
          if (!jmax) begin
            j_d = j_q + 1'b1;
          end else begin
            j_d = '0;
            if (i_q != r - 1'b1) begin
              i_d = i_q + 1'b1;
            end else begin
              i_d     = '0;
              state_d = (state_q == ST_PASS1) ? ST_DRAIN : ST_LOAD;
            end
          end
        end
      end
      ST_DRAIN: begin
        // let the last stage-one sum retire into the partial store
        if (!drain_busy_i) state_d = ST_PASS2;
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

// ----- hdl/wtt_datapath.sv -----
// ----------------------------------------------------------------------------
// wtt_datapath: tile/partial stores, one MAC unit, round/saturate, output reg
// Products flow through a three-stage pipe: operand read, multiply, accumulate.
// ----------------------------------------------------------------------------
module wtt_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [2:0]                mode_i,
  input  logic                      invert_i,
  input  logic                      load_we_i,
  input  logic [wtt_pkg::AddrW-1:0] load_addr_i,
  input  logic signed [31:0]        element_i,
  input  wtt_pkg::mac_cmd_t         cmd_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [31:0]        value_o,
  output logic                      last_o
);
  import wtt_pkg::*;

  logic signed [31:0] tile_mem [StoreDepth];
  logic signed [31:0] part_mem [StoreDepth];

  logic [IdxW-1:0]  n;
  logic [AddrW-1:0] total, rd_addr, tidx;
  logic             rev;
  logic signed [17:0] c_d;

  // stage A: operand read
  logic               a_v_q, a_first_q, a_lastk_q, a_lastel_q, a_st2_q;
  logic [AddrW-1:0]   a_waddr_q;
  logic signed [31:0] a_x_q;
  logic signed [17:0] a_c_q;
  // stage B: product
  logic               b_v_q, b_first_q, b_lastk_q, b_lastel_q, b_st2_q;
  logic [AddrW-1:0]   b_waddr_q;
  logic signed [49:0] b_p_q;
  // accumulator
  logic signed [AccW-1:0] acc_q, acc_d, rnd;
  logic signed [31:0]     sat;
  logic                   out_valid_q, out_last_q;
  logic signed [31:0]     out_value_q;

  assign n     = size_in(mode_i);
  assign total = AddrW'(n) * AddrW'(n);
  assign rev   = (mode_i == 3'(MODE_WEIGHT)) && invert_i;
  assign tidx  = AddrW'(cmd_i.k) * AddrW'(n) + AddrW'(cmd_i.j);

  // Operand addressing
  always_comb begin
    if (cmd_i.stage2) begin
      rd_addr = AddrW'(cmd_i.i) * AddrW'(n) + AddrW'(cmd_i.k);
      c_d     = coef(mode_i, cmd_i.j, cmd_i.k);
    end else begin
      rd_addr = rev ? (total - 1'b1 - tidx) : tidx;
      c_d     = coef(mode_i, cmd_i.i, cmd_i.k);
    end
  end

  // Tile store
  always_ff @(posedge clk_i) begin
    if (load_we_i) tile_mem[load_addr_i] <= element_i;
  end

  // Operand and product stages
  always_ff @(posedge clk_i) begin
    a_x_q      <= cmd_i.stage2 ? part_mem[rd_addr] : tile_mem[rd_addr];
    a_c_q      <= c_d;
    a_first_q  <= cmd_i.first;
    a_lastk_q  <= cmd_i.last_k;
    a_lastel_q <= cmd_i.last_el;
    a_st2_q    <= cmd_i.stage2;
    a_waddr_q  <= AddrW'(cmd_i.i) * AddrW'(n) + AddrW'(cmd_i.j);
    b_p_q      <= a_x_q * a_c_q;
    b_first_q  <= a_first_q;
    b_lastk_q  <= a_lastk_q;
    b_lastel_q <= a_lastel_q;
    b_st2_q    <= a_st2_q;
    b_waddr_q  <= a_waddr_q;
  end

  // Pipe valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      a_v_q <= cmd_i.fire;
      b_v_q <= a_v_q;
    end
  end

  // Accumulate, then round half up and saturate
  assign acc_d = (b_first_q ? AccW'(0) : acc_q) + AccW'(b_p_q);
  assign rnd   = (acc_d + AccW'(1 << (FracBits - 1))) >>> FracBits;
  always_comb begin
    if (rnd > AccW'(32'sh7fffffff))       sat = 32'sh7fffffff;
    else if (rnd < -AccW'(64'sh80000000)) sat = 32'sh80000000;
    else                                  sat = rnd[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (b_v_q) acc_q <= acc_d;
    if (b_v_q && b_lastk_q && !b_st2_q) part_mem[b_waddr_q] <= sat;
    if (b_v_q && b_lastk_q && b_st2_q) begin
      out_value_q <= sat;
      out_last_q  <= b_lastel_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_v_q && b_lastk_q && b_st2_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Busy while products are in flight or a result waits
  assign busy_o      = a_v_q || b_v_q || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign last_o      = out_last_q;

endmodule

// ----- hdl/winograd_tile_transform.sv -----
// ----------------------------------------------------------------------------
// winograd_tile_transform: Winograd F(4x4,3x3) tile transform, Q16.16
// Loads a tile, computes A*X*A^T with a mode-selected matrix, streams result.
// ----------------------------------------------------------------------------
//  channel  | signals                        | direction
//  input    | in_valid_i/in_ready_o, element | into block
//  output   | out_valid_o/out_ready_i, value,last | out of block
//  config   | cfg_we_i, cfg_index_i, cfg_data_i | into block
//
// One element per cycle while loading; then r*n*n products (pass 1), one per
// cycle on a single 32x18 MAC, and the last sum drains to the partial store.
// Pass 2 spends n products on each of the r*r results.
// Each result waits for the output register; stalls hold the MAC pass.
// Reset clears control state only; no clearing pass is needed.
module winograd_tile_transform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [2:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] element_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic               last_o
);
  import wtt_pkg::*;

  logic [2:0]       mode_q;
  logic             invert_q;
  logic             load_we, busy;
  logic [AddrW-1:0] load_addr;
  mac_cmd_t         cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 3'(MODE_WEIGHT);
      invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE:   mode_q   <= cfg_data_i;
        REG_INVERT: invert_q <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  wtt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .mode_i        (mode_q),
    .cfg_restart_i (cfg_we_i),
    .in_valid_i,
    .in_ready_o,
    .load_we_o     (load_we),
    .load_addr_o   (load_addr),
    .cmd_o         (cmd),
    .drain_busy_i  (busy)
  );

  wtt_datapath u_dp (
    .clk_i, .rst_ni,
    .mode_i      (mode_q),
    .invert_i    (invert_q),
    .load_we_i   (load_we),
    .load_addr_i (load_addr),
    .element_i,
    .cmd_i       (cmd),
    .busy_o      (busy),
    .out_valid_o,
    .out_ready_i,
    .value_o,
    .last_o
  );

endmodule

// ----- hdl/wtt_checker.sv -----
// ----------------------------------------------------------------------------
// wtt_checker: port-level checks for the tile transform
// ----------------------------------------------------------------------------
module wtt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] value_o,
  input logic        last_o
);
  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(last_o))
    else $error("result changed under stall");

  // Handshake outputs are always driven
  a_hs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_o, out_valid_o}))
    else $error("handshake output unknown");

  // After last result no immediate further result
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> !out_valid_o)
    else $error("result after last");
endmodule

bind winograd_tile_transform wtt_checker u_chk (.*);
